// ===== rtl/bra_pkg.sv =====
// bra_pkg: shared types and constants of the bitmap run allocator
// no dependencies; used by the interfaces and every rtl module

package bra_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned CFG_W  = 8;
  localparam int unsigned WORD_W = 32;

  // carry of free bits across words, always below the run length
  localparam int unsigned CARRY_W = 12;

  typedef enum logic [CMD_W-1:0] {
    CMD_SCAN  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_TEST  = 2'd3
  } bra_cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN,
    ST_DONE
  } bra_state_e;

  // per-word scan summary
  typedef struct packed {
    logic       hit_b;  // a whole run fits inside the word
    logic [4:0] ib;     // lowest end position of such a run
    logic [5:0] tz;     // free bits counted up from bit 0
    logic [5:0] lz;     // free bits counted down from bit 31
  } bra_word_info_t;

endpackage

// ===== rtl/bra_intf.sv =====
// bra_intf: request, response and configuration channels of the allocator
// depends on bra_pkg for field widths

interface bra_req_if;
  logic                        valid;
  logic                        ready;
  logic [bra_pkg::CMD_W-1:0]   cmd;
  logic [bra_pkg::IDX_W-1:0]   bit_index;
  logic [bra_pkg::LEN_W-1:0]   run_length;
  logic                        bit_value;

  modport source (output valid, cmd, bit_index, run_length, bit_value, input ready);
  modport sink   (input valid, cmd, bit_index, run_length, bit_value, output ready);
endinterface

interface bra_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [bra_pkg::IDX_W-1:0]   start_index;
  logic                        bit_read;

  modport source (output valid, found, start_index, bit_read, input ready);
  modport sink   (input valid, found, start_index, bit_read, output ready);
endinterface

interface bra_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bra_pkg::CFG_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/bitmap_run_allocator_top.sv =====
// bitmap_run_allocator_top: first-fit run allocator over a word-organized bitmap
// depends on bra_pkg, bra_intf, bra_mem, bra_word_eval and bra_ctrl
//
//  channel  dir  handshake      payload
//  req_i    in   valid / ready  cmd, bit_index, run_length, bit_value
//  rsp_o    out  valid / ready  found, start_index, bit_read
//  cfg_i    in   valid / ready  data (bytes_in_use), ready tied high
//
// one request at a time; write and test read, then modify or test, then respond
// scan reads one 32-bit word per cycle from the single memory read port,
//   up to the last active word, stopping at the first fit
// clear-all sweeps (MAP_BITS+31)/32 words, one per cycle, then responds
// after reset the same sweep runs with req_i.ready low
// a finished response waits in the output register while the next request is taken

module bitmap_run_allocator_top #(
  parameter int unsigned MAP_BITS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bra_req_if.sink     req_i,
  bra_rsp_if.source   rsp_o,
  bra_cfg_if.sink     cfg_i
);

  localparam int unsigned WordCount = (MAP_BITS + 31) / 32;
  localparam int unsigned AW        = (WordCount > 1) ? $clog2(WordCount) : 1;
  localparam int unsigned LW        = $clog2(MAP_BITS + 1);
  localparam int unsigned MaxBytes  = MAP_BITS / 8;
  localparam int unsigned BW        = ((LW > bra_pkg::CFG_W) ? LW : bra_pkg::CFG_W) + 3;
  localparam logic [bra_pkg::CFG_W-1:0] CfgReset = 8'd128;

  // active bit count: byte count saturated to the map size, times eight
  function automatic logic [LW-1:0] limit_of(input logic [bra_pkg::CFG_W-1:0] bytes);
    logic [BW-1:0] clipped;
    clipped = (BW'(bytes) > BW'(MaxBytes)) ? BW'(MaxBytes) : BW'(bytes);
    return LW'(clipped << 3);
  endfunction

  logic [LW-1:0]                  limit_q;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [bra_pkg::WORD_W-1:0]     mem_wdata;
  logic                           mem_re;
  logic [AW-1:0]                  mem_raddr;
  logic [bra_pkg::WORD_W-1:0]     mem_rdata;
  logic                           ev_in_vld;
  logic [AW-1:0]                  ev_in_idx;
  logic [bra_pkg::LEN_W-1:0]      run_len;
  logic                           ev_out_vld;
  logic [AW-1:0]                  ev_out_idx;
  bra_pkg::bra_word_info_t        ev_info;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= limit_of(CfgReset);
    end else if (cfg_i.valid) begin
      limit_q <= limit_of(cfg_i.data);
    end
  end

  bra_ctrl #(
    .MAP_BITS (MAP_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .limit_i     (limit_q),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .ev_vld_o    (ev_in_vld),
    .ev_idx_o    (ev_in_idx),
    .run_len_o   (run_len),
    .ev_vld_i    (ev_out_vld),
    .ev_idx_i    (ev_out_idx),
    .ev_info_i   (ev_info)
  );

  bra_mem #(
    .DEPTH  (WordCount),
    .ADDR_W (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bra_word_eval #(
    .MAP_BITS (MAP_BITS)
  ) u_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (ev_in_vld),
    .idx_i     (ev_in_idx),
    .word_i    (mem_rdata),
    .limit_i   (limit_q),
    .run_len_i (run_len),
    .out_vld_o (ev_out_vld),
    .idx_o     (ev_out_idx),
    .info_o    (ev_info)
  );

  // read and write never share a cycle, so no same-word forwarding is needed
  a_mem_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("memory read and write in the same cycle");

  // a word handed to the scan stage comes from a read issued the cycle before
  a_eval_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_in_vld |-> $past(mem_re))
    else $error("scan word without a preceding memory read");

  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mem_waddr <= AW'(WordCount - 1)))
    else $error("memory write beyond the last word");

endmodule

// ===== rtl/bra_mem.sv =====
// bra_mem: bitmap word store, one write port and one read port, registered read
// depends on bra_pkg for the word width

module bra_mem #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = 5
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [ADDR_W-1:0]            waddr_i,
  input  logic [bra_pkg::WORD_W-1:0]   wdata_i,
  input  logic                         re_i,
  input  logic [ADDR_W-1:0]            raddr_i,
  output logic [bra_pkg::WORD_W-1:0]   rdata_o
);

  logic [bra_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic [bra_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bra_word_eval.sv =====
// bra_word_eval: registered per-word summary for the run scan
// depends on bra_pkg (bra_word_info_t, widths)

module bra_word_eval #(
  parameter  int unsigned MAP_BITS = 1024,
  localparam int unsigned WordCount = (MAP_BITS + 31) / 32,
  localparam int unsigned AW = (WordCount > 1) ? $clog2(WordCount) : 1,
  localparam int unsigned LW = $clog2(MAP_BITS + 1),
  localparam int unsigned CW = (LW > AW + 5) ? LW : AW + 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_vld_i,
  input  logic [AW-1:0]                 idx_i,
  input  logic [bra_pkg::WORD_W-1:0]    word_i,
  input  logic [LW-1:0]                 limit_i,
  input  logic [bra_pkg::LEN_W-1:0]     run_len_i,
  output logic                          out_vld_o,
  output logic [AW-1:0]                 idx_o,
  output bra_pkg::bra_word_info_t       info_o
);

  logic [CW-1:0]              lim_c;
  logic [CW-1:0]              idx_c;
  logic [31:0]                mask;
  logic [31:0]                free;
  logic [31:0]                ext [6];
  logic [31:0]                win;
  logic [5:0]                 win_off;
  logic                       len_ok;
  bra_pkg::bra_word_info_t    info;

  logic                       out_vld_q;
  logic [AW-1:0]              idx_q;
  bra_pkg::bra_word_info_t    info_q;

  assign lim_c = CW'(limit_i);
  assign idx_c = CW'(idx_i);

  // bits at or past the active limit count as used
  always_comb begin
    priority if (idx_c < (lim_c >> 5)) begin
      mask = '1;
    end else if (idx_c == (lim_c >> 5)) begin
      mask = (32'd1 << lim_c[4:0]) - 32'd1;
    end else begin
      mask = '0;
    end
  end

  assign free   = ~word_i & mask;
  assign len_ok = (run_len_i <= 11'd32);

  // ext[k]: free window of 2**k bits ending at each position,
  // then windows are chained along the binary digits of the run length
  always_comb begin
    ext[0]  = free;
    for (int k = 1; k < 6; k++) begin
      ext[k] = ext[k-1] & (ext[k-1] << (1 << (k - 1)));
    end
    win     = '1;
    win_off = '0;
    for (int b = 0; b < 6; b++) begin
      if (run_len_i[b]) begin
        win     = win & (ext[b] << win_off);
        win_off = win_off + 6'(1 << b);
      end
    end
  end

  always_comb begin
    info.hit_b = len_ok && (|win);
    info.ib    = '0;
    for (int j = 31; j >= 0; j--) begin
      if (win[j]) begin
        info.ib = 5'(j);
      end
    end
    info.tz = 6'd32;
    for (int j = 31; j >= 0; j--) begin
      if (!free[j]) begin
        info.tz = 6'(j);
      end
    end
    info.lz = 6'd32;
    for (int j = 0; j < 32; j++) begin
      if (!free[j]) begin
        info.lz = 6'(31 - j);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_i) begin
      idx_q  <= idx_i;
      info_q <= info;
    end
  end

  assign out_vld_o = out_vld_q;
  assign idx_o     = idx_q;
  assign info_o    = info_q;

endmodule

// ===== rtl/bra_ctrl.sv =====
// bra_ctrl: command sequencer, clearing sweep, scan combine and response register
// depends on bra_pkg and the bra_req_if / bra_rsp_if channels

module bra_ctrl #(
  parameter  int unsigned MAP_BITS = 1024,
  localparam int unsigned WordCount = (MAP_BITS + 31) / 32,
  localparam int unsigned AW = (WordCount > 1) ? $clog2(WordCount) : 1,
  localparam int unsigned LW = $clog2(MAP_BITS + 1),
  localparam int unsigned XW = AW + 5,
  localparam int unsigned IW = (LW > bra_pkg::IDX_W) ? LW : bra_pkg::IDX_W,
  localparam int unsigned SW = (XW > 12) ? XW : 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bra_req_if.sink                       req_i,
  bra_rsp_if.source                     rsp_o,
  input  logic [LW-1:0]                 limit_i,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [bra_pkg::WORD_W-1:0]    mem_wdata_o,
  output logic                          mem_re_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  logic [bra_pkg::WORD_W-1:0]    mem_rdata_i,
  output logic                          ev_vld_o,
  output logic [AW-1:0]                 ev_idx_o,
  output logic [bra_pkg::LEN_W-1:0]     run_len_o,
  input  logic                          ev_vld_i,
  input  logic [AW-1:0]                 ev_idx_i,
  input  bra_pkg::bra_word_info_t       ev_info_i
);

  bra_pkg::bra_state_e            state_q, state_d;
  bra_pkg::bra_cmd_e              cmd_q;
  logic [bra_pkg::IDX_W-1:0]      idx_q;
  logic [bra_pkg::LEN_W-1:0]      len_q;
  logic                           val_q;
  logic                           inrng_q;
  logic [AW-1:0]                  rd_ptr_q, rd_ptr_d;
  logic                           rd_end_q, rd_end_d;
  logic                           rd_vld_q;
  logic [AW-1:0]                  rd_idx_q;
  logic [bra_pkg::CARRY_W-1:0]    carry_q, carry_d;
  logic [AW-1:0]                  clr_ptr_q, clr_ptr_d;
  logic                           clr_rsp_q, clr_rsp_d;
  logic                           res_found_q, res_found_d;
  logic [bra_pkg::IDX_W-1:0]      res_start_q, res_start_d;
  logic                           res_read_q, res_read_d;
  logic                           out_valid_q, out_valid_d;
  logic                           out_found_q;
  logic [bra_pkg::IDX_W-1:0]      out_start_q;
  logic                           out_read_q;

  logic                           accept;
  logic                           issue;
  logic                           out_load;
  logic [XW-1:0]                  req_idx_x;
  logic [XW-1:0]                  cur_idx_x;
  logic                           req_inrng;
  logic [LW-1:0]                  lim_m1;
  logic [AW-1:0]                  last_word;
  logic [SW-1:0]                  base;
  logic [SW-1:0]                  start_a;
  logic [SW-1:0]                  start_b;
  logic                           hit_a;

  assign req_idx_x = XW'(req_i.bit_index);
  assign cur_idx_x = XW'(idx_q);
  assign req_inrng = (IW'(req_i.bit_index) < IW'(limit_i));
  assign lim_m1    = limit_i - LW'(1);
  assign last_word = AW'(lim_m1 >> 5);

  // run that continues from the previous words, or one inside this word
  assign hit_a   = (carry_q + bra_pkg::CARRY_W'(ev_info_i.tz))
                   >= bra_pkg::CARRY_W'(len_q);
  assign base    = SW'(ev_idx_i) << 5;
  assign start_a = base - SW'(carry_q);
  assign start_b = base + SW'(ev_info_i.ib) + SW'(1) - SW'(len_q);

  always_comb begin
    state_d     = state_q;
    rd_ptr_d    = rd_ptr_q;
    rd_end_d    = rd_end_q;
    carry_d     = carry_q;
    clr_ptr_d   = clr_ptr_q;
    clr_rsp_d   = clr_rsp_q;
    res_found_d = res_found_q;
    res_start_d = res_start_q;
    res_read_d  = res_read_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_load    = 1'b0;
    accept      = 1'b0;
    issue       = 1'b0;
    req_i.ready = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    unique case (state_q)
      bra_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_ptr_q;
        if (clr_ptr_q == AW'(WordCount - 1)) begin
          clr_ptr_d = '0;
          state_d   = clr_rsp_q ? bra_pkg::ST_DONE : bra_pkg::ST_IDLE;
        end else begin
          clr_ptr_d = clr_ptr_q + AW'(1);
        end
      end

      bra_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          accept      = 1'b1;
          res_found_d = 1'b1;
          res_start_d = '0;
          res_read_d  = 1'b0;
          unique case (bra_pkg::bra_cmd_e'(req_i.cmd))
            bra_pkg::CMD_SCAN: begin
              res_found_d = 1'b0;
              if ((req_i.run_length != '0) && (limit_i != '0)) begin
                rd_ptr_d = '0;
                rd_end_d = 1'b0;
                carry_d  = '0;
                state_d  = bra_pkg::ST_SCAN;
              end else begin
                state_d  = bra_pkg::ST_DONE;
              end
            end
            bra_pkg::CMD_WRITE,
            bra_pkg::CMD_TEST: begin
              mem_re_o    = 1'b1;
              mem_raddr_o = req_idx_x[XW-1:5];
              state_d     = bra_pkg::ST_ACCESS;
            end
            bra_pkg::CMD_CLEAR: begin
              clr_rsp_d = 1'b1;
              clr_ptr_d = '0;
              state_d   = bra_pkg::ST_CLEAR;
            end
          endcase
        end
      end

      bra_pkg::ST_ACCESS: begin
        if (cmd_q == bra_pkg::CMD_WRITE) begin
          mem_we_o                   = inrng_q;
          mem_waddr_o                = cur_idx_x[XW-1:5];
          mem_wdata_o                = mem_rdata_i;
          mem_wdata_o[idx_q[4:0]]    = val_q;
        end else begin
          res_read_d = inrng_q && mem_rdata_i[idx_q[4:0]];
        end
        state_d = bra_pkg::ST_DONE;
      end

      bra_pkg::ST_SCAN: begin
        if (!rd_end_q) begin
          issue       = 1'b1;
          mem_re_o    = 1'b1;
          mem_raddr_o = rd_ptr_q;
          rd_ptr_d    = rd_ptr_q + AW'(1);
          rd_end_d    = (rd_ptr_q == last_word);
        end
        if (ev_vld_i) begin
          priority if (hit_a) begin
            res_found_d = 1'b1;
            res_start_d = start_a[bra_pkg::IDX_W-1:0];
            state_d     = bra_pkg::ST_DONE;
          end else if (ev_info_i.hit_b) begin
            res_found_d = 1'b1;
            res_start_d = start_b[bra_pkg::IDX_W-1:0];
            state_d     = bra_pkg::ST_DONE;
          end else begin
            carry_d = (ev_info_i.tz == 6'd32) ? carry_q + bra_pkg::CARRY_W'(32)
                                             : bra_pkg::CARRY_W'(ev_info_i.lz);
            if (ev_idx_i == last_word) begin
              state_d = bra_pkg::ST_DONE;
            end
          end
        end
      end

      bra_pkg::ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          clr_rsp_d   = 1'b0;
          state_d     = bra_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bra_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bra_pkg::ST_CLEAR;
      rd_ptr_q    <= '0;
      rd_end_q    <= 1'b0;
      rd_vld_q    <= 1'b0;
      carry_q     <= '0;
      clr_ptr_q   <= '0;
      clr_rsp_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_ptr_q    <= rd_ptr_d;
      rd_end_q    <= rd_end_d;
      rd_vld_q    <= issue;
      carry_q     <= carry_d;
      clr_ptr_q   <= clr_ptr_d;
      clr_rsp_q   <= clr_rsp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= bra_pkg::bra_cmd_e'(req_i.cmd);
      idx_q   <= req_i.bit_index;
      len_q   <= req_i.run_length;
      val_q   <= req_i.bit_value;
      inrng_q <= req_inrng;
    end
    if (issue) begin
      rd_idx_q <= rd_ptr_q;
    end
    res_found_q <= res_found_d;
    res_start_q <= res_start_d;
    res_read_q  <= res_read_d;
    if (out_load) begin
      out_found_q <= res_found_q;
      out_start_q <= res_start_q;
      out_read_q  <= res_read_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.found       = out_found_q;
  assign rsp_o.start_index = out_start_q;
  assign rsp_o.bit_read    = out_read_q;

  assign ev_vld_o  = rd_vld_q;
  assign ev_idx_o  = rd_idx_q;
  assign run_len_o = len_q;

endmodule
